// ===== rtl/rwr_pkg.sv =====
// rwr_pkg: constants, codes, payload types and the sequence wrap helper
// for the receive window block; every other file imports it
package rwr_pkg;

    localparam int WINDOW_SLOTS = 5;
    localparam int SEQ_SPACE    = 30720;
    localparam int MAX_PAYLOAD  = 1020;

    localparam int SEQ_W  = 15;
    localparam int SIZE_W = 10;
    localparam int SLOT_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_STORED   = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_RELEASED = 2'd2,
        KIND_BASE_SET = 2'd3
    } kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } back_state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [SEQ_W-1:0]  seq;
        logic [SIZE_W-1:0] size;
    } cmd_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  seg_seq;
        logic [SIZE_W-1:0] seg_size;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  next_base;
        logic              last;
    } result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // value is below twice the sequence space, so one subtract wraps it
    function automatic logic [SEQ_W-1:0] wrap_seq(input logic [SEQ_W:0] v);
        logic [SEQ_W:0] r;
        if (v >= (SEQ_W+1)'(SEQ_SPACE))
        begin
            r = v - (SEQ_W+1)'(SEQ_SPACE);
        end
        else
        begin
            r = v;
        end
        return r[SEQ_W-1:0];
    endfunction

endpackage

// ===== rtl/rwr_if.sv =====
// rwr_if: valid/ready channel interfaces for input items and results
// depends on rwr_pkg
interface rwr_in_if import rwr_pkg::*; ();
    logic              valid;
    logic              ready;
    cmd_t              cmd;
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;

    modport source (output valid, cmd, seq, size, input ready);
    modport sink   (input valid, cmd, seq, size, output ready);
endinterface

interface rwr_out_if import rwr_pkg::*; ();
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [SEQ_W-1:0]  seg_seq;
    logic [SIZE_W-1:0] seg_size;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  next_base;
    logic              last;

    modport source (output valid, kind, seg_seq, seg_size, slot, next_base, last,
                    input ready);
    modport sink   (input valid, kind, seg_seq, seg_size, slot, next_base, last,
                    output ready);
endinterface

// ===== rtl/rwr_front.sv =====
// rwr_front: accepts input items, wraps the sequence and clamps the size,
// then pushes them into the command queue; depends on rwr_pkg, rwr_if
module rwr_front import rwr_pkg::*;
(
    rwr_in_if.sink        item,
    input  queue_status_t q_status,
    output logic          push,
    output cmd_item_t     push_item
);

    assign item.ready = !q_status.full;
    assign push       = item.valid && !q_status.full;

    always_comb
    begin
        push_item.cmd = item.cmd;
        push_item.seq = wrap_seq({1'b0, item.seq});
        if (item.size > SIZE_W'(MAX_PAYLOAD))
        begin
            push_item.size = SIZE_W'(MAX_PAYLOAD);
        end
        else
        begin
            push_item.size = item.size;
        end
    end

endmodule

// ===== rtl/rwr_queue.sv =====
// rwr_queue: short command queue between the front and the back end
// depends on rwr_pkg
module rwr_queue import rwr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_item_t     push_item,
    input  logic          pop,
    output cmd_item_t     pop_item,
    output queue_status_t status
);

    cmd_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/rwr_back.sv =====
// rwr_back: window slots, expected base and the release sequencer that
// turns queued commands into results; depends on rwr_pkg, rwr_if
module rwr_back import rwr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  cmd_item_t     pop_item,
    output logic          pop,
    rwr_out_if.source     result
);

    back_state_t       state_reg, state_next;
    logic              slot_valid_reg [WINDOW_SLOTS];
    logic [SEQ_W-1:0]  slot_seq_reg   [WINDOW_SLOTS];
    logic [SIZE_W-1:0] slot_size_reg  [WINDOW_SLOTS];
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              out_free;
    logic              load_out;
    logic              store_en;
    logic              clear_en;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              hit_found;
    logic [SLOT_W-1:0] hit_idx;
    logic [WINDOW_SLOTS-1:0] match;
    logic [WINDOW_SLOTS-1:0] more;
    logic [SEQ_W:0]    rel_sum;
    logic [SEQ_W-1:0]  rel_base;
    logic              store_match;

    assign out_free = !out_valid_reg || result.ready;

    // lowest free slot and lowest slot holding the expected base
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        hit_found  = 1'b0;
        hit_idx    = '0;
        for (int i = WINDOW_SLOTS - 1; i >= 0; i--)
        begin
            match[i] = slot_valid_reg[i] && (slot_seq_reg[i] == base_reg);
            if (!slot_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (match[i])
            begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(i);
            end
        end
    end

    assign rel_sum  = {1'b0, slot_seq_reg[hit_idx]} + (SEQ_W+1)'(slot_size_reg[hit_idx]);
    assign rel_base = wrap_seq(rel_sum);

    // does another slot continue the chain after this release
    always_comb
    begin
        for (int i = 0; i < WINDOW_SLOTS; i++)
        begin
            more[i] = slot_valid_reg[i] && (SLOT_W'(i) != hit_idx)
                      && (slot_seq_reg[i] == rel_base);
        end
    end

    assign store_match = (|match) || (free_found && (pop_item.seq == base_reg));

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        store_en   = 1'b0;
        clear_en   = 1'b0;
        out_next   = out_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty && out_free)
                begin
                    pop      = 1'b1;
                    load_out = 1'b1;
                    if (pop_item.cmd == CMD_START)
                    begin
                        base_next          = pop_item.seq;
                        out_next.kind      = KIND_BASE_SET;
                        out_next.seg_seq   = '0;
                        out_next.seg_size  = '0;
                        out_next.slot      = '0;
                        out_next.next_base = pop_item.seq;
                        out_next.last      = 1'b1;
                    end
                    else
                    begin
                        store_en           = free_found;
                        out_next.kind      = free_found ? KIND_STORED : KIND_REJECTED;
                        out_next.seg_seq   = pop_item.seq;
                        out_next.seg_size  = pop_item.size;
                        out_next.slot      = free_found ? free_idx : '0;
                        out_next.next_base = base_reg;
                        out_next.last      = !store_match;
                        if (store_match)
                        begin
                            state_next = BK_SCAN;
                        end
                    end
                end
            end
            BK_SCAN:
            begin
                if (out_free)
                begin
                    load_out           = 1'b1;
                    clear_en           = hit_found;
                    base_next          = rel_base;
                    out_next.kind      = KIND_RELEASED;
                    out_next.seg_seq   = slot_seq_reg[hit_idx];
                    out_next.seg_size  = slot_size_reg[hit_idx];
                    out_next.slot      = hit_idx;
                    out_next.next_base = rel_base;
                    out_next.last      = !(|more);
                    if (!(|more))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_SLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            if (store_en)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
            end
            if (clear_en)
            begin
                slot_valid_reg[hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            slot_seq_reg[free_idx]  <= pop_item.seq;
            slot_size_reg[free_idx] <= pop_item.size;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.kind      = out_reg.kind;
    assign result.seg_seq   = out_reg.seg_seq;
    assign result.seg_size  = out_reg.seg_size;
    assign result.slot      = out_reg.slot;
    assign result.next_base = out_reg.next_base;
    assign result.last      = out_reg.last;

endmodule

// ===== rtl/receive_window_reorder_release_top.sv =====
// channel  | dir | handshake     | payload
// item     | in  | valid / ready | cmd, seq, size
// result   | out | valid / ready | kind, seg_seq, seg_size, slot, next_base, last
//
// a start item gives one base set result in the back end; an insert gives its
// store or reject result, then one release per chained segment (up to five),
// as the back end does a single release compare and base add per result.
// items enter a two-entry queue at one per cycle while it has room.
// reset empties the window, clears the base to zero and flushes the queue.
// a stalled result holds the back end; the queue keeps taking items until full.
//
// receive_window_reorder_release_top: front, queue and back end of the
// receive window; depends on rwr_pkg, rwr_if, rwr_front, rwr_queue, rwr_back
module receive_window_reorder_release_top import rwr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rwr_in_if.sink    item,
    rwr_out_if.source result
);

    logic          push;
    cmd_item_t     push_item;
    logic          pop;
    cmd_item_t     pop_item;
    queue_status_t q_status;

    rwr_front u_front
    (
        .item      (item),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    rwr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    rwr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_item (pop_item),
        .pop      (pop),
        .result   (result)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("back end popped an empty queue");

    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.cmd == CMD_START) |=>
        (result.valid && result.kind == KIND_BASE_SET && result.last))
        else $error("start command did not give a final base set result");

    a_base_set_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == KIND_BASE_SET) |->
        (result.seg_seq == '0 && result.slot == '0 && result.last))
        else $error("base set result carries segment fields");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: drives inserts and base sets into the receive window, predicts every
// stored, rejected, released and base set result, checks them in order
// depends on rwr_pkg, rwr_if and receive_window_reorder_release_top
module testbench;
    import rwr_pkg::*;

    localparam int RANDOM_ITEMS  = 180;
    localparam int STEADY_AFTER  = 170;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RAW_SEQ_MAX   = (1 << SEQ_W) - 1;
    localparam int RAW_SIZE_MAX  = (1 << SIZE_W) - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rwr_in_if  item_ch ();
    rwr_out_if result_ch ();

    receive_window_reorder_release_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always #5 clk = ~clk;

    // window as the testbench sees it
    logic win_valid [WINDOW_SLOTS] = '{default: 1'b0};
    int   win_seq   [WINDOW_SLOTS] = '{default: 0};
    int   win_size  [WINDOW_SLOTS] = '{default: 0};
    int   win_base = 0;

    cmd_item_t pending_items [$];
    result_t   window_results_due [$];
    cmd_item_t next_item;

    int items_queued;
    int items_accepted = 0;
    int send_gap;
    int ready_hold;
    int mismatch_count = 0;
    int cycle_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic result_t window_result(input kind_t k, input int sq, input int sz,
                                              input int sl);
        result_t r;
        r.kind      = k;
        r.seg_seq   = SEQ_W'(sq);
        r.seg_size  = SIZE_W'(sz);
        r.slot      = SLOT_W'(sl);
        r.next_base = SEQ_W'(win_base);
        r.last      = 1'b0;
        return r;
    endfunction

    // updates the window for one transfer and queues the results it causes
    function automatic void predict_window(input cmd_t c, input logic [SEQ_W-1:0] raw_seq,
                                           input logic [SIZE_W-1:0] raw_size);
        int sq;
        int sz;
        int free_slot;
        int hit;
        result_t r;
        sq = int'(raw_seq) % SEQ_SPACE;
        sz = (int'(raw_size) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(raw_size);
        if (c == CMD_START)
        begin
            win_base = sq;
            r = window_result(KIND_BASE_SET, 0, 0, 0);
        end
        else
        begin
            free_slot = -1;
            for (int i = WINDOW_SLOTS - 1; i >= 0; i--)
                if (!win_valid[i])
                    free_slot = i;
            if (free_slot >= 0)
            begin
                win_valid[free_slot] = 1'b1;
                win_seq[free_slot]   = sq;
                win_size[free_slot]  = sz;
                r = window_result(KIND_STORED, sq, sz, free_slot);
            end
            else
            begin
                r = window_result(KIND_REJECTED, sq, sz, 0);
            end
            hit = 0;
            while (hit >= 0)
            begin
                hit = -1;
                for (int i = WINDOW_SLOTS - 1; i >= 0; i--)
                    if (win_valid[i] && win_seq[i] == win_base)
                        hit = i;
                if (hit >= 0)
                begin
                    window_results_due.push_back(r);
                    win_valid[hit] = 1'b0;
                    win_base = (win_seq[hit] + win_size[hit]) % SEQ_SPACE;
                    r = window_result(KIND_RELEASED, win_seq[hit], win_size[hit], hit);
                end
            end
        end
        r.last = 1'b1;
        window_results_due.push_back(r);
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (window_results_due.size() == 0)
        begin
            report_mismatch("result with nothing due, kind", int'(got.kind), -1);
        end
        else
        begin
            want = window_results_due.pop_front();
            if (got.kind != want.kind)
                report_mismatch("kind", int'(got.kind), int'(want.kind));
            if (got.seg_seq != want.seg_seq)
                report_mismatch("seg_seq", got.seg_seq, want.seg_seq);
            if (got.seg_size != want.seg_size)
                report_mismatch("seg_size", got.seg_size, want.seg_size);
            if (got.slot != want.slot)
                report_mismatch("slot", got.slot, want.slot);
            if (got.next_base != want.next_base)
                report_mismatch("next_base", got.next_base, want.next_base);
            if (got.last != want.last)
                report_mismatch("last", got.last, want.last);
        end
    endtask

    // driver: one pending item per transfer, with short random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.cmd   <= CMD_START;
            item_ch.seq   <= '0;
            item_ch.size  <= '0;
            send_gap      <= 0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (send_gap > 0)
            begin
                item_ch.valid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (items_accepted < STEADY_AFTER && $urandom_range(0, 6) == 0)
            begin
                item_ch.valid <= 1'b0;
                send_gap      <= $urandom_range(0, 2);
            end
            else if (pending_items.size() > 0)
            begin
                next_item     = pending_items.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.cmd   <= next_item.cmd;
                item_ch.seq   <= next_item.seq;
                item_ch.size  <= next_item.size;
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on each item transfer, checks each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_hold      <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_window(item_ch.cmd, item_ch.seq, item_ch.size);
                items_accepted <= items_accepted + 1;
            end
            if (result_ch.valid && result_ch.ready)
                check_result('{kind: result_ch.kind, seg_seq: result_ch.seg_seq,
                               seg_size: result_ch.seg_size, slot: result_ch.slot,
                               next_base: result_ch.next_base, last: result_ch.last});
            if (ready_hold > 0)
            begin
                result_ch.ready <= 1'b0;
                ready_hold      <= ready_hold - 1;
            end
            else if (items_accepted < STEADY_AFTER && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                ready_hold      <= $urandom_range(0, 2);
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic queue_item(input cmd_t c, input int sq, input int sz);
        pending_items.push_back('{cmd: c, seq: SEQ_W'(sq), size: SIZE_W'(sz)});
        items_queued++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || window_results_due.size() != 0)
            @(negedge clk);
    endtask

    // releases whatever is left in the window: set the base on a leftover,
    // then insert a zero size segment where that leftover ends
    task automatic empty_window();
        int open_slot;
        for (int tries = 0; tries < 12; tries++)
        begin
            wait_drained();
            open_slot = -1;
            for (int i = WINDOW_SLOTS - 1; i >= 0; i--)
                if (win_valid[i])
                    open_slot = i;
            if (open_slot < 0)
                break;
            queue_item(CMD_START, win_seq[open_slot], 0);
            queue_item(CMD_INSERT, (win_seq[open_slot] + win_size[open_slot]) % SEQ_SPACE, 0);
        end
        wait_drained();
    endtask

    function automatic int encode_seq(input int sq);
        // low sequences may also be sent in their out of range form
        if (sq + SEQ_SPACE <= RAW_SEQ_MAX && $urandom_range(0, 3) == 0)
            return sq + SEQ_SPACE;
        return sq;
    endfunction

    // start, then a contiguous run of segments in shuffled order
    task automatic queue_segment_run();
        int run_base;
        int run_len;
        int chain;
        int pick;
        int tmp;
        int drop_at;
        int seg_seq  [8];
        int seg_size [8];
        if ($urandom_range(0, 3) == 0)
            run_base = $urandom_range(SEQ_SPACE - 3000, SEQ_SPACE - 1);
        else
            run_base = $urandom_range(0, SEQ_SPACE - 1);
        run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
        queue_item(CMD_START, encode_seq(run_base), $urandom_range(0, RAW_SIZE_MAX));
        chain = run_base;
        for (int i = 0; i < run_len; i++)
        begin
            pick = $urandom_range(0, 9);
            seg_seq[i] = chain;
            if (pick == 0)
                seg_size[i] = 0;
            else if (pick == 1)
                seg_size[i] = $urandom_range(MAX_PAYLOAD + 1, RAW_SIZE_MAX);
            else
                seg_size[i] = $urandom_range(1, MAX_PAYLOAD);
            chain = (chain + ((seg_size[i] > MAX_PAYLOAD) ? MAX_PAYLOAD : seg_size[i]))
                    % SEQ_SPACE;
        end
        for (int i = run_len - 1; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            tmp = seg_seq[i];
            seg_seq[i] = seg_seq[pick];
            seg_seq[pick] = tmp;
            tmp = seg_size[i];
            seg_size[i] = seg_size[pick];
            seg_size[pick] = tmp;
        end
        // now and then a hole in the run
        drop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, run_len - 1) : -1;
        for (int i = 0; i < run_len; i++)
            if (i != drop_at)
                queue_item(CMD_INSERT, encode_seq(seg_seq[i]), seg_size[i]);
        if ($urandom_range(0, 7) == 0)
            queue_item(CMD_INSERT, encode_seq(seg_seq[0]), seg_size[0]);
    endtask

    initial
    begin
        int directed_items;
        int rounds;
        items_queued   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_item(CMD_START, 0, RAW_SIZE_MAX);
        queue_item(CMD_INSERT, 0, 0);
        queue_item(CMD_INSERT, 0, RAW_SIZE_MAX);
        queue_item(CMD_START, RAW_SEQ_MAX, 0);
        queue_item(CMD_INSERT, RAW_SEQ_MAX, MAX_PAYLOAD);
        // chain across the wrap, sent back to front, then the window fills up
        queue_item(CMD_START, 30000, 0);
        queue_item(CMD_INSERT, 1020, 5);
        queue_item(CMD_INSERT, 1020, 0);
        queue_item(CMD_INSERT, 0, MAX_PAYLOAD + 1);
        queue_item(CMD_INSERT, 30700, 20);
        queue_item(CMD_INSERT, 5000, 1);
        queue_item(CMD_INSERT, 30000, 700);
        queue_item(CMD_START, 30700, 0);
        queue_item(CMD_INSERT, SEQ_SPACE, 0);
        queue_item(CMD_START, SEQ_SPACE - 1, 0);
        queue_item(CMD_INSERT, SEQ_SPACE - 1, 1);
        queue_item(CMD_INSERT, SEQ_SPACE - 1, 0);
        empty_window();

        directed_items = items_queued;
        rounds = 0;
        while (items_queued < directed_items + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    queue_item(cmd_t'($urandom_range(0, 1)), $urandom_range(0, RAW_SEQ_MAX),
                               $urandom_range(0, RAW_SIZE_MAX));
            end
            else
            begin
                queue_segment_run();
            end
            rounds++;
            if (rounds % 8 == 0)
                empty_window();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rwr_pkg.sv
rtl/rwr_if.sv
rtl/rwr_front.sv
rtl/rwr_queue.sv
rtl/rwr_back.sv
rtl/receive_window_reorder_release_top.sv
tb/testbench.sv
